// ----- src/masked_byte_pattern_scanner_macros.svh -----
// Assertion helpers shared by the scanner modules.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define MBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define MBPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ----- src/mbps_pkg.sv -----
`default_nettype none

package mbps_pkg;

  localparam int unsigned MaxPattern    = 8;
  localparam int unsigned EvtQueueDepth = 4;
  localparam int unsigned AddrWidth     = 64;
  localparam int unsigned CountWidth    = 32;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 64;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegPattern    = 3'd0,
    RegCareMask   = 3'd1,
    RegPatLen     = 3'd2,
    RegScanMode   = 3'd3,
    RegOccurrence = 3'd4,
    RegOffset     = 3'd5,
    RegBase       = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [7:0]  care_mask;
    logic [3:0]  pattern_length;
    logic        scan_mode;
    logic [30:0] occurrence;
    logic [31:0] match_offset;
    logic [63:0] base_address;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    pattern_bytes:  64'd0,
    care_mask:      8'hFF,
    pattern_length: 4'd1,
    scan_mode:      1'b0,
    occurrence:     31'd1,
    match_offset:   32'd0,
    base_address:   64'd0
  };

  // One classified byte, as handed from front to back.
  typedef struct packed {
    logic                  hit;    // match result to report
    logic                  nth;    // match is the nth occurrence (offset, ends scan)
    logic [CountWidth-1:0] start;  // match start within the range
    logic                  term;   // not-found / end-of-range terminator follows
  } evt_t;

endpackage

`default_nettype wire

// ----- src/mbps_front.sv -----
`default_nettype none
`include "masked_byte_pattern_scanner_macros.svh"

module mbps_front #(
  parameter int unsigned MaxPattern = mbps_pkg::MaxPattern
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire mbps_pkg::cfg_t  cfg_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  [7:0]           data_byte_i,
  input  wire                  last_byte_i,
  output logic                 evt_valid_o,
  output mbps_pkg::evt_t       evt_o,
  input  wire                  evt_ready_i
);

  localparam int unsigned LenW = $clog2(MaxPattern + 1);
  localparam int unsigned IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned CntW = mbps_pkg::CountWidth;

  logic [7:0]      win_q [MaxPattern];
  logic [7:0]      shift_win [MaxPattern];
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] count_q, count_d, count_inc;
  logic            done_q, done_d;
  logic [LenW-1:0] len;
  logic            window_hit;
  logic            enough;
  logic            nth_hit;
  logic [CntW-1:0] start;
  logic            accept;

  assign in_ready_o = evt_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  // Clamp the configured length into 1..MaxPattern.
  always_comb begin
    if (cfg_i.pattern_length == 4'd0) begin
      len = LenW'(1);
    end else if (cfg_i.pattern_length > 4'(MaxPattern)) begin
      len = LenW'(MaxPattern);
    end else begin
      len = cfg_i.pattern_length[LenW-1:0];
    end
  end

  // Window as it stands after taking this byte; entry 0 is the newest.
  always_comb begin
    shift_win[0] = data_byte_i;
    for (int i = 1; i < MaxPattern; i++) begin
      shift_win[i] = win_q[i-1];
    end
  end

  // Pattern byte j lines up with window entry len-1-j.
  always_comb begin
    logic [LenW-1:0] idx;
    window_hit = 1'b1;
    for (int j = 0; j < MaxPattern; j++) begin
      idx = len - LenW'(j) - LenW'(1);
      if ((LenW'(j) < len) && cfg_i.care_mask[j] &&
          (shift_win[idx[IdxW-1:0]] != cfg_i.pattern_bytes[8*j +: 8])) begin
        window_hit = 1'b0;
      end
    end
  end

  assign enough    = pos_q >= (CntW'(len) - CntW'(1));
  assign start     = pos_q + CntW'(1) - CntW'(len);
  assign count_inc = (count_q == '1) ? count_q : count_q + CntW'(1);
  assign nth_hit   = (cfg_i.occurrence != '0) && (count_inc == {1'b0, cfg_i.occurrence});

  always_comb begin
    pos_d       = pos_q;
    count_d     = count_q;
    done_d      = done_q;
    evt_o       = '0;
    evt_valid_o = 1'b0;
    if (accept) begin
      if (!done_q) begin
        pos_d = pos_q + CntW'(1);
        if (enough && window_hit) begin
          if (cfg_i.scan_mode) begin
            evt_o.hit   = 1'b1;
            evt_o.start = start;
          end else begin
            count_d = count_inc;
            if (nth_hit) begin
              evt_o.hit   = 1'b1;
              evt_o.nth   = 1'b1;
              evt_o.start = start;
              done_d      = 1'b1;
            end
          end
        end
        evt_o.term  = last_byte_i & (cfg_i.scan_mode | ~done_d);
        evt_valid_o = evt_o.hit | evt_o.term;
      end
      // End of range: start the next one afresh.
      if (last_byte_i) begin
        pos_d   = '0;
        count_d = '0;
        done_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Window bytes are only compared once this range has filled them.
  always_ff @(posedge clk_i) begin
    if (accept && !done_q) begin
      win_q <= shift_win;
    end
  end

  `MBPS_ASSERT(a_done_has_count, done_q |-> (count_q != '0), "scan done with no match counted")

endmodule

`default_nettype wire

// ----- src/mbps_fifo.sv -----
`default_nettype none
`include "masked_byte_pattern_scanner_macros.svh"

module mbps_fifo #(
  parameter int unsigned Depth = mbps_pkg::EvtQueueDepth
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire mbps_pkg::evt_t  data_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 valid_o,
  output mbps_pkg::evt_t       data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mbps_pkg::evt_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `MBPS_ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into a full event queue")
  `MBPS_ASSERT_NEVER(a_no_underflow, pop_i && !valid_o, "pop from an empty event queue")

endmodule

`default_nettype wire

// ----- src/mbps_back.sv -----
`default_nettype none
`include "masked_byte_pattern_scanner_macros.svh"

module mbps_back (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire mbps_pkg::cfg_t                 cfg_i,
  input  wire                                 evt_valid_i,
  input  wire mbps_pkg::evt_t                 evt_i,
  output logic                                evt_pop_o,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [mbps_pkg::AddrWidth-1:0]      out_addr_o,
  output logic                                out_found_o,
  output logic                                out_end_o
);

  localparam int unsigned AW = mbps_pkg::AddrWidth;

  logic [AW-1:0] nth_base_q;
  logic          sent_q, sent_d;
  logic          out_valid_q, out_valid_d;
  logic [AW-1:0] out_addr_q, out_addr_d;
  logic          out_found_q, out_found_d;
  logic          out_end_q, out_end_d;
  logic          out_free;
  logic          load;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    sent_d      = sent_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_addr_d  = out_addr_q;
    out_found_d = out_found_q;
    out_end_d   = out_end_q;
    evt_pop_o   = 1'b0;
    load        = 1'b0;
    if (out_free && evt_valid_i) begin
      load        = 1'b1;
      out_valid_d = 1'b1;
      if (evt_i.hit && !sent_q) begin
        out_found_d = 1'b1;
        out_end_d   = evt_i.nth;
        out_addr_d  = (evt_i.nth ? nth_base_q : cfg_i.base_address) +
                      {{(AW - mbps_pkg::CountWidth){1'b0}}, evt_i.start};
        // Hold the entry when its terminator still has to go out.
        sent_d      = evt_i.term;
        evt_pop_o   = ~evt_i.term;
      end else begin
        out_found_d = 1'b0;
        out_end_d   = 1'b1;
        out_addr_d  = '0;
        sent_d      = 1'b0;
        evt_pop_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nth_base_q  <= '0;
      sent_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      nth_base_q  <= cfg_i.base_address +
                     {{(AW - 32){cfg_i.match_offset[31]}}, cfg_i.match_offset};
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_addr_q  <= out_addr_d;
      out_found_q <= out_found_d;
      out_end_q   <= out_end_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_addr_o  = out_addr_q;
  assign out_found_o = out_found_q;
  assign out_end_o   = out_end_q;

  `MBPS_ASSERT(a_miss_zero_addr, (out_valid_q && !out_found_q) |-> (out_addr_q == '0),
    "not-found result carries a non-zero address")
  `MBPS_ASSERT(a_sent_holds_entry, sent_q |-> (evt_valid_i && evt_i.hit && evt_i.term),
    "split entry lost before its terminator went out")

endmodule

`default_nettype wire

// ----- src/masked_byte_pattern_scanner.sv -----
// Masked byte pattern scanner: wildcard byte signature search over a byte stream.
// Input channel s_axis: one memory byte per transaction, tlast on the final byte of
// the range. Output channel m_axis: one result per transaction, tdata the match
// address, tuser the found flag, tlast the end of the scan.
// Configure through cfg_we_i/cfg_idx_i/cfg_data_i between ranges only.
// Find-all mode gives base+start for every match, then a not-found terminator on
// the final byte; nth mode gives base+start+offset for the chosen occurrence and
// ignores the rest of the range, or a not-found result if it never comes.
// A result reaches m_axis through the event queue and then the output register:
// the byte's entry enters the queue at the edge that takes the byte, and the queue
// head moves into the output register once that register is free.
// Throughput: one byte per cycle; a final byte that also matches in find-all mode
// gives the back end two results from one queue entry, sent one after the other.
// The four-entry event queue absorbs that and any short receiver stall; s_axis_tready
// falls only when the queue is full.
// Reset clears the registers to their defaults, empties the queue and the output,
// and restarts the range at position zero.

`default_nettype none

module masked_byte_pattern_scanner #(
  parameter int unsigned MaxPattern    = mbps_pkg::MaxPattern,
  parameter int unsigned EvtQueueDepth = mbps_pkg::EvtQueueDepth
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Configuration writes
  input  wire                                  cfg_we_i,
  input  wire  [mbps_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  wire  [mbps_pkg::CfgDataWidth-1:0]    cfg_data_i,
  // Byte stream in
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [7:0]                           s_axis_tdata,   // [7:0] data_byte
  input  wire                                  s_axis_tlast,   // last_byte
  // Results out
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [mbps_pkg::AddrWidth-1:0]       m_axis_tdata,   // [63:0] match_address
  output logic                                 m_axis_tuser,   // [0] found
  output logic                                 m_axis_tlast    // scan_end
);

  mbps_pkg::cfg_t cfg_q;
  mbps_pkg::evt_t front_evt;
  mbps_pkg::evt_t head_evt;
  logic           front_evt_valid;
  logic           queue_full;
  logic           head_valid;
  logic           head_pop;

  // Configuration registers: take a write whenever the enable is high; drop
  // writes to indexes outside the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= mbps_pkg::CfgReset;
    end else if (cfg_we_i) begin
      unique case (mbps_pkg::cfg_reg_e'(cfg_idx_i))
        mbps_pkg::RegPattern:    cfg_q.pattern_bytes  <= cfg_data_i;
        mbps_pkg::RegCareMask:   cfg_q.care_mask      <= cfg_data_i[7:0];
        mbps_pkg::RegPatLen:     cfg_q.pattern_length <= cfg_data_i[3:0];
        mbps_pkg::RegScanMode:   cfg_q.scan_mode      <= cfg_data_i[0];
        mbps_pkg::RegOccurrence: cfg_q.occurrence     <= cfg_data_i[30:0];
        mbps_pkg::RegOffset:     cfg_q.match_offset   <= cfg_data_i[31:0];
        mbps_pkg::RegBase:       cfg_q.base_address   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: advance the window, compare, count occurrences and classify each byte
  // into at most one queue entry.
  mbps_front #(
    .MaxPattern (MaxPattern)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .evt_valid_o (front_evt_valid),
    .evt_o       (front_evt),
    .evt_ready_i (~queue_full)
  );

  // Event queue: lets the front keep taking bytes while the receiver stalls.
  mbps_fifo #(
    .Depth (EvtQueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_evt_valid),
    .data_i  (front_evt),
    .full_o  (queue_full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head_evt)
  );

  // Back: form the addresses and send results through the output register.
  mbps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .evt_valid_i (head_valid),
    .evt_i       (head_evt),
    .evt_pop_o   (head_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_addr_o  (m_axis_tdata),
    .out_found_o (m_axis_tuser),
    .out_end_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- tb/sv/masked_byte_pattern_scanner_tb.sv -----
`default_nettype none

module masked_byte_pattern_scanner_tb;
  import mbps_pkg::*;

  // scan_mode register values
  localparam logic ModeNth     = 1'b0;
  localparam logic ModeFindAll = 1'b1;

  // Cycles the sink holds off for during the back-pressure test.
  localparam int unsigned LongHoldCycles = 200;
  // Settle time after the last expected result: two stages of latency plus margin.
  localparam int unsigned SettleCycles = 4;

  // One result transaction as the scanner should present it.
  typedef struct packed {
    logic [63:0] address;
    logic        found;
    logic        scan_end;
  } scan_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    cfg_we_i   = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i  = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0; // last_byte

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // [63:0] match_address
  logic        m_axis_tuser;         // [0] found
  logic        m_axis_tlast;         // scan_end

  // Shadow copy of the scanner: configuration and per-range state.
  cfg_t        model_cfg = CfgReset;
  logic [7:0]  model_window [MaxPattern];
  logic [31:0] model_pos   = '0;
  logic [31:0] model_hits  = '0;
  logic        model_done  = 1'b0;

  scan_report_t awaited_reports [$];

  int unsigned mismatches   = 0;
  int unsigned live_bytes   = 0;  // bytes handed to the scanner so far
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  // Hold-off request: the test bumps hold_epoch, the sink process counts the stretch.
  int unsigned hold_epoch = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_count = 0;

  masked_byte_pattern_scanner DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sink: random stalls, or a long counted hold-off when the test asks for one.
  always @(posedge clk_i) begin
    if (hold_epoch != hold_seen) begin
      hold_seen     <= hold_epoch;
      hold_count    <= LongHoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_count != 0) begin
      hold_count    <= hold_count - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare every result transaction with the oldest awaited report, field by field.
  always @(posedge clk_i) begin : check_results
    scan_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected result: match_address %h found %b scan_end %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        if (m_axis_tdata !== want.address) begin
          $error("match_address: expected %h, got %h", want.address, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== want.found) begin
          $error("found: expected %b, got %b", want.found, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tlast !== want.scan_end) begin
          $error("scan_end: expected %b, got %b", want.scan_end, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Length 0 acts as 1, anything above the window size as the full window.
  function automatic int unsigned span_of(logic [3:0] len);
    if (len == 0) return 1;
    if (len > MaxPattern) return MaxPattern;
    return 32'(len);
  endfunction

  // Append one report at the tail of the awaited list.
  function automatic void post_report(scan_report_t r);
    awaited_reports = {awaited_reports, r};
  endfunction

  // Advance the shadow scanner by one accepted byte and queue the reports it causes.
  task automatic predict_scan_results(logic [7:0] b, logic last);
    int unsigned span;
    logic        hit;
    logic [31:0] start;
    logic [63:0] addr;
    if (!model_done) begin
      span = span_of(model_cfg.pattern_length);
      for (int i = MaxPattern - 1; i > 0; i--) model_window[i] = model_window[i-1];
      model_window[0] = b;
      // No match until the window holds a whole pattern; wildcards always agree.
      hit = (model_pos >= 32'(span - 1));
      for (int j = 0; j < span; j++)
        if (model_cfg.care_mask[j] &&
            model_window[span-1-j] != model_cfg.pattern_bytes[8*j +: 8])
          hit = 1'b0;
      if (hit) begin
        start = model_pos + 32'd1 - 32'(span);
        addr  = model_cfg.base_address + 64'(start);
        if (model_cfg.scan_mode == ModeFindAll) begin
          post_report(scan_report_t'{addr, 1'b1, 1'b0});
        end else begin
          if (model_hits != '1) model_hits++;
          // Occurrence zero never fires; the offset is signed and wraps the address.
          if (model_cfg.occurrence != 0 && model_hits == {1'b0, model_cfg.occurrence}) begin
            post_report(scan_report_t'{
              addr + {{32{model_cfg.match_offset[31]}}, model_cfg.match_offset},
              1'b1, 1'b1});
            model_done = 1'b1;
          end
        end
      end
      model_pos++;
      // Terminator: always in find-all mode, in nth mode only when nothing was reported.
      if (last && (model_cfg.scan_mode == ModeFindAll || !model_done))
        post_report(scan_report_t'{64'd0, 1'b0, 1'b1});
    end
    if (last) begin
      for (int i = 0; i < MaxPattern; i++) model_window[i] = 8'd0;
      model_pos  = '0;
      model_hits = '0;
      model_done = 1'b0;
    end
  endtask

  // Offer one byte, with a random idle gap first, and hold it until the transaction.
  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    live_bytes++;
    predict_scan_results(b, last);
  endtask

  // Drop valid and wait until every awaited report has come, then let the pipe settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all seven registers back to back; only call with the scanner idle.
  task automatic apply_config(cfg_t c);
    cfg_reg_e    idx;
    logic [63:0] val;
    for (int i = 0; i <= RegBase; i++) begin
      idx = cfg_reg_e'(i);
      case (idx)
        RegPattern:    val = c.pattern_bytes;
        RegCareMask:   val = 64'(c.care_mask);
        RegPatLen:     val = 64'(c.pattern_length);
        RegScanMode:   val = 64'(c.scan_mode);
        RegOccurrence: val = 64'(c.occurrence);
        RegOffset:     val = 64'(c.match_offset);
        default:       val = c.base_address;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= val;
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    model_cfg = c;
  endtask

  function automatic cfg_t random_setting();
    cfg_t c;
    c.pattern_bytes  = {$urandom, $urandom};
    c.pattern_length = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                : 4'($urandom_range(1, MaxPattern));
    case ($urandom_range(9))
      0:       c.care_mask = 8'h00;
      1, 2, 3: c.care_mask = 8'hFF;
      default: c.care_mask = 8'($urandom);
    endcase
    c.scan_mode = $urandom_range(1) ? ModeFindAll : ModeNth;
    case ($urandom_range(9))
      0:       c.occurrence = 31'd0;
      1:       c.occurrence = 31'h7FFF_FFFF;
      2:       c.occurrence = 31'($urandom);
      default: c.occurrence = 31'($urandom_range(1, 3));
    endcase
    case ($urandom_range(4))
      0:       c.match_offset = 32'h8000_0000;
      1:       c.match_offset = 32'h7FFF_FFFF;
      2:       c.match_offset = 32'd0;
      default: c.match_offset = $urandom;
    endcase
    case ($urandom_range(4))
      0:       c.base_address = 64'd0;
      1:       c.base_address = '1;
      2:       c.base_address = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(16));
      default: c.base_address = {$urandom, $urandom};
    endcase
    return c;
  endfunction

  // Build one range from whole pattern copies (wildcards filled at random) and noise.
  task automatic send_random_scan();
    int unsigned n_bytes;
    int unsigned span;
    logic [7:0]  scan_bytes [$];
    n_bytes = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 20);
    span    = span_of(model_cfg.pattern_length);
    while (scan_bytes.size() < n_bytes) begin
      if ($urandom_range(2) != 0) begin
        for (int k = 0; k < span; k++)
          scan_bytes = {scan_bytes, model_cfg.care_mask[k] ? model_cfg.pattern_bytes[8*k +: 8]
                                                           : 8'($urandom)};
      end else begin
        repeat ($urandom_range(1, 3)) scan_bytes = {scan_bytes, 8'($urandom)};
      end
    end
    for (int j = 0; j < n_bytes; j++) send_byte(scan_bytes[j], j == n_bytes - 1);
  endtask

  // Register defaults straight out of reset: pattern 00, length 1, first occurrence.
  task automatic test_reset_defaults();
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);   // first match, ends the scan
    send_byte(8'hFF, 1'b1);   // ignored, closes the range silently
    send_byte(8'hFF, 1'b1);   // one-byte range with no match
    drain_results();
  endtask

  task automatic test_directed_cases();
    cfg_t c;
    // Find-all, final byte also matches, address wraps past the top.
    c                = CfgReset;
    c.scan_mode      = ModeFindAll;
    c.pattern_bytes  = 64'h0000_0000_0000_FF00;
    c.care_mask      = 8'h03;
    c.pattern_length = 4'd2;
    c.base_address   = 64'hFFFF_FFFF_FFFF_FFFE;
    apply_config(c);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();

    // Nth mode, wildcard in the middle, second occurrence, most negative offset,
    // then bytes after the hit are ignored.
    c                = CfgReset;
    c.scan_mode      = ModeNth;
    c.pattern_bytes  = 64'h0000_0000_0000_5AFF;
    c.care_mask      = 8'h05;
    c.pattern_length = 4'd3;
    c.occurrence     = 31'd2;
    c.match_offset   = 32'h8000_0000;
    c.base_address   = 64'h10;
    apply_config(c);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b1);
    drain_results();

    // Occurrence zero with length zero and all wildcards: every byte matches,
    // nothing is reported, the range ends as not found.
    c                = CfgReset;
    c.pattern_length = 4'd0;
    c.care_mask      = 8'h00;
    c.occurrence     = 31'd0;
    c.match_offset   = 32'h7FFF_FFFF;
    apply_config(c);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    drain_results();

    // Oversized length acts as the full window; a shorter range gives only the terminator.
    c                = CfgReset;
    c.scan_mode      = ModeFindAll;
    c.pattern_bytes  = '1;
    c.pattern_length = 4'd15;
    c.base_address   = '1;
    apply_config(c);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();
  endtask

  // Random configurations and ranges under the given idling, until n_items bytes are sent.
  task automatic test_random_scans(int unsigned idle_pct, int unsigned stall_pct,
                                   int unsigned n_items);
    int unsigned goal;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    goal = live_bytes + n_items;
    while (live_bytes < goal) begin
      drain_results();
      apply_config(random_setting());
      repeat ($urandom_range(1, 4)) send_random_scan();
    end
    drain_results();
  endtask

  // Every byte matches; hold the sink off so the event queue fills and s_axis stalls.
  task automatic test_output_backpressure();
    cfg_t c;
    c              = CfgReset;
    c.scan_mode    = ModeFindAll;
    c.care_mask    = 8'h00;
    c.base_address = {$urandom, $urandom};
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    apply_config(c);
    hold_epoch++;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom), i == 39);
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < MaxPattern; i++) model_window[i] = 8'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_cases();
    test_random_scans(0, 0, 450);
    test_random_scans(64, 0, 450);
    test_random_scans(0, 64, 450);
    test_random_scans(15, 15, 450);
    test_output_backpressure();

    // Allow any stray result to surface before the verdict.
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("masked_byte_pattern_scanner_tb: clean");
    else
      $display("masked_byte_pattern_scanner_tb: errors");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("masked_byte_pattern_scanner_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
